@@ hdl/ecef_local_tangent_transform_unit_assert.svh @@
// Assertion macros shared by the checker of the local tangent transform unit
`ifndef ECEF_LOCAL_TANGENT_TRANSFORM_UNIT_ASSERT_SVH
`define ECEF_LOCAL_TANGENT_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ELT_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("local tangent transform assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ELT_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("local tangent transform assertion failed");

`endif

@@ hdl/elt_pkg.sv @@
// Shared constants, types and helpers of the local tangent transform unit
package elt_pkg;

    localparam int TRIG_FRAC_BITS = 30;
    localparam int POS_SHIFT      = 6;
    localparam logic signed [31:0] POS_DIVISOR = 32'sd25;
    // ceil(2^35 / 25): exact quotient for any magnitude up to 2^31
    localparam logic [31:0] RECIP_MUL   = 32'h51EB_851F;
    localparam int          RECIP_SHIFT = 35;
    localparam logic signed [31:0] TRIG_ONE = 32'sd1 <<< TRIG_FRAC_BITS;

    // Opcodes
    localparam logic [3:0] OP_ENU_PT      = 4'd0;
    localparam logic [3:0] OP_NED_PT      = 4'd1;
    localparam logic [3:0] OP_ENU_POS     = 4'd2;
    localparam logic [3:0] OP_NED_POS     = 4'd3;
    localparam logic [3:0] OP_ECEF_VECT   = 4'd4;
    localparam logic [3:0] OP_ECEF_ENU_PT = 4'd5;
    localparam logic [3:0] OP_ECEF_NED_PT = 4'd6;
    localparam logic [3:0] OP_ECEF_ENU_POS = 4'd7;
    localparam logic [3:0] OP_ECEF_NED_POS = 4'd8;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_SIN_LAT  = 3'd3;
    localparam logic [2:0] CFG_COS_LAT  = 3'd4;
    localparam logic [2:0] CFG_SIN_LON  = 3'd5;
    localparam logic [2:0] CFG_COS_LON  = 3'd6;

    // Rotation matrix and origin as seen by the datapath
    typedef struct packed {
        logic signed [31:0] r0;
        logic signed [31:0] r1;
        logic signed [31:0] r3;
        logic signed [31:0] r4;
        logic signed [31:0] r5;
        logic signed [31:0] r6;
        logic signed [31:0] r7;
        logic signed [31:0] r8;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
    } mtx_t;

    // Arithmetic shift by the trig fraction and keep the low word
    function automatic logic signed [31:0] fin(input logic signed [63:0] s);
        logic signed [63:0] sh;
        sh = s >>> TRIG_FRAC_BITS;
        return sh[31:0];
    endfunction

endpackage

@@ hdl/elt_matrix.sv @@
// Configuration registers and the rotation matrix built from them
module elt_matrix
    import elt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    output mtx_t        mtx
);

    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [31:0] sin_lat_reg, cos_lat_reg, sin_lon_reg, cos_lon_reg;
    logic signed [63:0] p_sc_reg, p_ss_reg, p_cc_reg, p_cs_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            sin_lat_reg  <= '0;
            cos_lat_reg  <= TRIG_ONE;
            sin_lon_reg  <= '0;
            cos_lon_reg  <= TRIG_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_wr_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_wr_data;
                CFG_ORIGIN_Z: origin_z_reg <= cfg_wr_data;
                CFG_SIN_LAT:  sin_lat_reg  <= cfg_wr_data;
                CFG_COS_LAT:  cos_lat_reg  <= cfg_wr_data;
                CFG_SIN_LON:  sin_lon_reg  <= cfg_wr_data;
                CFG_COS_LON:  cos_lon_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Trig cross products, one stage
    always_ff @(posedge clk)
    begin
        p_sc_reg <= sin_lat_reg * cos_lon_reg;
        p_ss_reg <= sin_lat_reg * sin_lon_reg;
        p_cc_reg <= cos_lat_reg * cos_lon_reg;
        p_cs_reg <= cos_lat_reg * sin_lon_reg;
    end

    // Scale the products to matrix entries
    always_comb
    begin
        mtx.r0 = 32'sd0 - sin_lon_reg;
        mtx.r1 = cos_lon_reg;
        mtx.r3 = fin(64'sd0 - p_sc_reg);
        mtx.r4 = fin(64'sd0 - p_ss_reg);
        mtx.r5 = cos_lat_reg;
        mtx.r6 = fin(p_cc_reg);
        mtx.r7 = fin(p_cs_reg);
        mtx.r8 = sin_lat_reg;
        mtx.ox = origin_x_reg;
        mtx.oy = origin_y_reg;
        mtx.oz = origin_z_reg;
    end

endmodule

@@ hdl/elt_datapath.sv @@
// Seven-stage conversion pipeline with per-stage valid bits
module elt_datapath
    import elt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mtx_t               mtx,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    logic [3:0]         op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] a2_reg [3];
    logic signed [31:0] c2_reg [9];
    logic signed [63:0] p3_reg [9];
    logic signed [31:0] w4_reg [3];
    logic [31:0]        mag5_reg [3];
    logic               neg5_reg [3];
    logic signed [31:0] val5_reg [3];
    logic [63:0]        q6_reg [3];
    logic               neg6_reg [3];
    logic signed [31:0] val6_reg [3];
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;

    logic signed [31:0] a1_next [3];
    logic signed [31:0] c2_next [9];
    logic signed [31:0] w4_next [3];
    logic [31:0]        mag5_next [3];
    logic               neg5_next [3];
    logic signed [31:0] val5_next [3];
    logic signed [31:0] res_next [3];

    // A stage advances when it is empty or the next one advances
    assign en7 = !v7_reg || !out_stall;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // Move valid bits down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // Stage 1: subtract origin, or swap a local NED vector and scale a local position
    always_comb
    begin
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] v [3];
        vx = in_x;
        vy = in_y;
        vz = in_z;
        if (opcode == OP_ECEF_NED_PT || opcode == OP_ECEF_NED_POS)
        begin
            vx = in_y;
            vy = in_x;
            vz = 32'sd0 - in_z;
        end
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (int k = 0; k < 3; k++)
        begin
            if (opcode <= OP_NED_POS)
                a1_next[k] = v[k];
            else if (opcode == OP_ECEF_ENU_POS || opcode == OP_ECEF_NED_POS)
                a1_next[k] = (v[k] * POS_DIVISOR) >>> POS_SHIFT;
            else
                a1_next[k] = v[k];
        end
        if (opcode <= OP_NED_POS)
        begin
            a1_next[0] = in_x - mtx.ox;
            a1_next[1] = in_y - mtx.oy;
            a1_next[2] = in_z - mtx.oz;
        end
    end

    // Stage 2: pick matrix rows for the direction of the transform
    always_comb
    begin
        if (op1_reg <= OP_NED_POS)
        begin
            c2_next[0] = mtx.r0; c2_next[1] = mtx.r1; c2_next[2] = 32'sd0;
            c2_next[3] = mtx.r3; c2_next[4] = mtx.r4; c2_next[5] = mtx.r5;
            c2_next[6] = mtx.r6; c2_next[7] = mtx.r7; c2_next[8] = mtx.r8;
        end
        else
        begin
            c2_next[0] = mtx.r0; c2_next[1] = mtx.r3; c2_next[2] = mtx.r6;
            c2_next[3] = mtx.r1; c2_next[4] = mtx.r4; c2_next[5] = mtx.r7;
            c2_next[6] = 32'sd0; c2_next[7] = mtx.r5; c2_next[8] = mtx.r8;
        end
    end

    // Stage 4: sum each row and scale back
    always_comb
    begin
        logic signed [63:0] s;
        for (int j = 0; j < 3; j++)
        begin
            s = p3_reg[3*j] + p3_reg[3*j+1] + p3_reg[3*j+2];
            w4_next[j] = fin(s);
        end
    end

    // Stage 5: split sign and magnitude for the divide, add origin for ECEF points and positions
    always_comb
    begin
        logic [31:0] t;
        logic signed [31:0] o [3];
        o[0] = mtx.ox;
        o[1] = mtx.oy;
        o[2] = mtx.oz;
        for (int j = 0; j < 3; j++)
        begin
            t = w4_reg[j] << POS_SHIFT;
            neg5_next[j] = t[31];
            mag5_next[j] = t[31] ? (32'd0 - t) : t;
            if (op4_reg <= OP_ECEF_VECT)
                val5_next[j] = w4_reg[j];
            else
                val5_next[j] = w4_reg[j] + o[j];
        end
    end

    // Stage 7: finish the divide, reorder NED, clear unused opcodes
    always_comb
    begin
        logic [31:0] q;
        logic signed [31:0] r [3];
        for (int j = 0; j < 3; j++)
        begin
            q = 32'(q6_reg[j] >> RECIP_SHIFT);
            if (op6_reg == OP_ENU_POS || op6_reg == OP_NED_POS)
                r[j] = neg6_reg[j] ? (32'sd0 - q) : q;
            else
                r[j] = val6_reg[j];
        end
        res_next[0] = r[0];
        res_next[1] = r[1];
        res_next[2] = r[2];
        if (op6_reg == OP_NED_PT || op6_reg == OP_NED_POS)
        begin
            res_next[0] = r[1];
            res_next[1] = r[0];
            res_next[2] = 32'sd0 - r[2];
        end
        else if (op6_reg > OP_ECEF_NED_POS)
        begin
            res_next[0] = '0;
            res_next[1] = '0;
            res_next[2] = '0;
        end
    end

    // Payload registers, loaded as each stage advances
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg <= opcode;
            for (int k = 0; k < 3; k++) a1_reg[k] <= a1_next[k];
        end
        if (en2)
        begin
            op2_reg <= op1_reg;
            for (int k = 0; k < 3; k++) a2_reg[k] <= a1_reg[k];
            for (int k = 0; k < 9; k++) c2_reg[k] <= c2_next[k];
        end
        if (en3)
        begin
            op3_reg <= op2_reg;
            for (int k = 0; k < 9; k++) p3_reg[k] <= c2_reg[k] * a2_reg[k % 3];
        end
        if (en4)
        begin
            op4_reg <= op3_reg;
            for (int j = 0; j < 3; j++) w4_reg[j] <= w4_next[j];
        end
        if (en5)
        begin
            op5_reg <= op4_reg;
            for (int j = 0; j < 3; j++)
            begin
                mag5_reg[j] <= mag5_next[j];
                neg5_reg[j] <= neg5_next[j];
                val5_reg[j] <= val5_next[j];
            end
        end
        if (en6)
        begin
            op6_reg <= op5_reg;
            for (int j = 0; j < 3; j++)
            begin
                q6_reg[j]   <= 64'(mag5_reg[j]) * 64'(RECIP_MUL);
                neg6_reg[j] <= neg5_reg[j];
                val6_reg[j] <= val5_reg[j];
            end
        end
        if (en7)
        begin
            res_x_reg <= res_next[0];
            res_y_reg <= res_next[1];
            res_z_reg <= res_next[2];
        end
    end

    assign out_valid = v7_reg;
    assign out_x = res_x_reg;
    assign out_y = res_y_reg;
    assign out_z = res_z_reg;

endmodule

@@ hdl/ecef_local_tangent_transform_unit.sv @@
// Top level of the ECEF / local tangent plane transform unit
// Takes one vector beat per clock while in_stall is low; a stalled output holds
// each full stage that has no empty stage ahead of it, and a bubble lets the
// stages behind it move up. The seven register stages are origin subtract or
// input scaling, coefficient select, the nine 32x32 multipliers, row sums,
// divide setup or origin add, the reciprocal multiply for the divide by 25, and
// the output register. A configuration write reaches the registered matrix
// products in the following cycle, in time for any beat accepted after it.
module ecef_local_tangent_transform_unit
    import elt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    mtx_t mtx;

    // Matrix and origin from the configuration registers
    elt_matrix u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .mtx        (mtx)
    );

    // Conversion pipeline
    elt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .mtx      (mtx),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .in_x     (in_x),
        .in_y     (in_y),
        .in_z     (in_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z)
    );

endmodule

@@ hdl/elt_checker.sv @@
// Port-level checker for the transform unit, bound to the top level
`include "ecef_local_tangent_transform_unit_assert.svh"

module elt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z
);

    logic busy;

    // A beat entered or the output was held back
    assign busy = (in_valid && !in_stall) || out_stall;

    // Hold a stalled result beat
    `ELT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `ELT_ASSERT_NXT(a_out_stable, out_valid && out_stall,
        $stable(out_x) && $stable(out_y) && $stable(out_z))
    // Input backs up only behind a stalled output
    `ELT_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
    // An idle stretch with no beat entering and no output stall drains the pipe
    `ELT_ASSERT_IMP(a_drain, !$past(busy, 1) && !$past(busy, 2) && !$past(busy, 3) &&
        !$past(busy, 4) && !$past(busy, 5) && !$past(busy, 6) && !$past(busy, 7),
        !out_valid)

endmodule

bind ecef_local_tangent_transform_unit elt_checker u_checker (.*);
